// File: rtl/fas_pkg.sv
package fas_pkg;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        last_item;
	} in_item_t;

	typedef struct packed {
		logic [31:0] sorted_bits;
		logic        last_out;
		logic        overflow_seen;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// Controls broadcast from the sequencer to every cell in the chain.
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

	function automatic logic [31:0] order_key(input logic [31:0] bits);
		order_key = bits[31] ? ~bits : (bits | 32'h8000_0000);
	endfunction

endpackage

// File: rtl/fas_cell.sv
module fas_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  fas_pkg::cell_ctrl_t ctrl,
	input  logic [31:0]       new_bits,
	input  logic [31:0]       left_bits,
	input  logic              left_valid,
	input  logic              left_greater,
	input  logic [31:0]       right_bits,
	input  logic              right_valid,
	output logic [31:0]       bits_out,
	output logic              valid_out,
	output logic              greater_out
);
	import fas_pkg::*;

	logic [31:0] bits_q;
	logic        valid_q;

	// A cell is greater than the new value if it holds one with a larger key.
	assign greater_out = valid_q && (order_key(bits_q) > order_key(new_bits));
	assign bits_out    = bits_q;
	assign valid_out   = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && (greater_out || (!valid_q && left_valid))) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			bits_q <= right_bits;
		end else if (ctrl.insert) begin
			if (greater_out) begin
				bits_q <= left_greater ? left_bits : new_bits;
			end else if (!valid_q && left_valid) begin
				bits_q <= left_greater ? left_bits : new_bits;
			end
		end
	end

endmodule

// File: rtl/float_array_sort.sv
// Ascending sort of IEEE single-precision bit patterns, ordered by the
// totalOrder key: negative NaNs first, -0 before +0, positive NaNs last.
// The in channel takes one value per beat; last_item closes the set. Each
// value is inserted into a chain of MAX_ELEMENTS cells in the cycle it is
// accepted, so input runs at one beat per cycle while a set fills.
// After the closing beat the chain shifts out towards the out channel, one
// result per cycle while out is not stalled, smallest first; last_out marks
// the final result and overflow_seen is set on every result if values
// beyond capacity were dropped. After the closing beat the state register
// moves to drain, and the first result is then registered on out. While a
// set drains, in is stalled, so a new set waits until the last result is
// loaded. A stall on out holds the output register and the chain. Reset
// empties the chain at once and leaves no result pending.
module float_array_sort #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fas_pkg::in_item_t  in_data,
	input  logic               in_valid,
	output logic               in_stall,
	output fas_pkg::out_item_t out_data,
	output logic               out_valid,
	input  logic               out_stall
);
	import fas_pkg::*;

	localparam int N = MAX_ELEMENTS;

	state_t      state_q, state_nx;
	cell_ctrl_t  ctrl;
	logic        ovf_q;
	logic        in_acc, load_out, chain_full;
	logic [31:0] bits   [N+1];
	logic        valid  [N+1];
	logic        greater[N+1];

	// Slot N stands before cell 0 and after the last cell: never valid, never greater.
	assign bits[N]    = '0;
	assign valid[N]   = 1'b0;
	assign greater[N] = 1'b0;

	genvar i;
	generate
		for (i = 0; i < N; i++) begin : g_cell
			fas_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.new_bits    (in_data.value_bits),
				.left_bits   (bits[(i == 0) ? N : i-1]),
				.left_valid  ((i == 0) ? 1'b1 : valid[(i == 0) ? N : i-1]),
				.left_greater(greater[(i == 0) ? N : i-1]),
				.right_bits  (bits[i+1]),
				.right_valid (valid[i+1]),
				.bits_out    (bits[i]),
				.valid_out   (valid[i]),
				.greater_out (greater[i])
			);
		end
	endgenerate

	assign chain_full = valid[N-1];
	assign in_stall   = (state_q != ST_FILL);
	assign in_acc     = in_valid && !in_stall;
	assign load_out   = (state_q == ST_DRAIN) && valid[0] && (!out_valid || !out_stall);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_FILL:  if (in_acc && in_data.last_item) state_nx = ST_DRAIN;
			ST_DRAIN: if (load_out && !valid[1]) state_nx = ST_FILL;
			default:  state_nx = ST_FILL;
		endcase
	end

	always_comb begin
		ctrl.insert = in_acc && !chain_full;
		ctrl.shift  = load_out;
		ctrl.clear  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (in_acc && chain_full) ovf_q <= 1'b1;
			if (load_out && !valid[1]) ovf_q <= 1'b0;
			if (load_out) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data.sorted_bits   <= bits[0];
			out_data.last_out      <= !valid[1];
			out_data.overflow_seen <= ovf_q;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	a_no_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> in_stall)
		else $error("input open while draining");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> valid[0])
		else $error("drain with empty chain");

endmodule
